// ===== rtl/frti_pkg.sv =====
// frti_pkg: shared constants and stage record types for the round-to-integral core
// no dependencies
`timescale 1ns / 1ps

package frti_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned DblMant = 52;
  localparam int unsigned DblExpW = 11;
  localparam int unsigned SglMant = 23;
  localparam int unsigned SglExpW = 8;
  localparam logic [10:0] DblBias = 11'd1023;
  localparam logic [10:0] DblExpAll = 11'h7ff;
  localparam logic [7:0] SglBias = 8'd127;
  localparam logic [7:0] SglExpAll = 8'hff;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_SMALL = 2'd1,
    KIND_FRAC  = 2'd2
  } kind_t;

  // stage 1 record: classification and fraction mask
  typedef struct packed {
    logic              ceil_op;
    logic              single;
    logic              neg;
    kind_t             kind;
    logic [DataW-1:0]  x;
    logic [DataW-1:0]  mask;
  } s1_t;

  // stage 2 record: truncated value and increment decision
  typedef struct packed {
    logic              single;
    kind_t             kind;
    logic              neg;
    logic              ceil_op;
    logic              frac_nz;
    logic [DataW-1:0]  x;
    logic [DataW-1:0]  trunc;
    logic [DataW-1:0]  unit;
  } s2_t;

endpackage

// ===== rtl/fp_round_to_integral_core.sv =====
// fp_round_to_integral_core: floor/ceil of an IEEE-754 double or single
// depends on frti_pkg and frti_stage
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries action (0 floor, 1 ceil),
//   is_single and operand_bits; a single sits in bits 31..0.
//   Output channel (out_valid/out_ready) carries result_bits and inexact,
//   one result per input transaction, in order.
//   Each transaction passes through three register stages, s1_q, s2_q and
//   s3_q, before out_valid rises with its result. Stage one
//   classifies and builds the fraction mask, stage two truncates and picks
//   the increment, stage three adds the unit and selects the result.
//   Throughput is one transaction per cycle while out_ready is high; each stage
//   is a register slot whose ready depends on its own valid and the slot after it.
//   When the receiver stalls, the stages fill up and in_ready drops once
//   all three hold data; nothing is lost or repeated.
//   Reset clears the valid bits of all stages; the data registers are not reset.
module fp_round_to_integral_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        is_single,
  input  logic [63:0] operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_bits,
  output logic        inexact
);

  frti_pkg::s1_t s1_d, s1_q;
  frti_pkg::s2_t s2_d, s2_q;
  logic [64:0]   s3_d, s3_q;
  logic          v1, v2, r1, r2;
  logic          ld1, ld2, ld3;

  // stage one: classify and build mask
  always_comb begin
    logic [63:0] x;
    logic [10:0] be;
    logic [5:0]  sh;
    logic        zero;
    logic [10:0] sb;
    x    = is_single ? {32'd0, operand_bits[31:0]} : operand_bits;
    zero = is_single ? (x[30:0] == 31'd0) : (x[62:0] == 63'd0);
    sb   = {3'd0, x[30:23]};
    be   = x[62:52];
    s1_d.ceil_op = action;
    s1_d.single  = is_single;
    s1_d.x       = x;
    sh           = '0;
    s1_d.kind    = frti_pkg::KIND_PASS;
    if (is_single) begin
      s1_d.neg = x[31];
      if (zero || sb[7:0] == frti_pkg::SglExpAll || sb >= 11'd150) begin
        s1_d.kind = frti_pkg::KIND_PASS;
      end else if (sb[7:0] < frti_pkg::SglBias) begin
        s1_d.kind = frti_pkg::KIND_SMALL;
      end else begin
        s1_d.kind = frti_pkg::KIND_FRAC;
        sh = 6'(11'd150 - sb);
      end
    end else begin
      s1_d.neg = x[63];
      if (zero || be == frti_pkg::DblExpAll || be >= 11'd1075) begin
        s1_d.kind = frti_pkg::KIND_PASS;
      end else if (be < frti_pkg::DblBias) begin
        s1_d.kind = frti_pkg::KIND_SMALL;
      end else begin
        s1_d.kind = frti_pkg::KIND_FRAC;
        sh = 6'(11'd1075 - be);
      end
    end
    s1_d.mask = ~(64'hffff_ffff_ffff_ffff << sh);
  end

  frti_stage u_s1 (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(v1), .out_ready(r1), .load(ld1)
  );

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_q <= s1_d;
    end
  end

  // stage two: truncate and choose unit
  always_comb begin
    s2_d.single  = s1_q.single;
    s2_d.kind    = s1_q.kind;
    s2_d.neg     = s1_q.neg;
    s2_d.ceil_op = s1_q.ceil_op;
    s2_d.x       = s1_q.x;
    s2_d.frac_nz = (s1_q.x & s1_q.mask) != 64'd0;
    s2_d.trunc   = s1_q.x & ~s1_q.mask;
    s2_d.unit    = (s1_q.ceil_op != s1_q.neg) ? s1_q.mask + 64'd1 : 64'd0;
  end

  frti_stage u_s2 (
    .clk(clk), .rst(rst), .in_valid(v1), .in_ready(r1),
    .out_valid(v2), .out_ready(r2), .load(ld2)
  );

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_q <= s2_d;
    end
  end

  // stage three: add unit and select result
  always_comb begin
    logic [63:0] one, sgn, res;
    logic        inx;
    one = s2_q.single ? {32'd0, 1'b0, frti_pkg::SglBias, 23'd0}
                      : {1'b0, frti_pkg::DblBias, 52'd0};
    sgn = s2_q.single ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    res = s2_q.x;
    inx = 1'b0;
    unique case (s2_q.kind)
      frti_pkg::KIND_SMALL: begin
        inx = 1'b1;
        if (s2_q.ceil_op) res = s2_q.neg ? sgn : one;
        else              res = s2_q.neg ? (sgn | one) : 64'd0;
      end
      frti_pkg::KIND_FRAC: begin
        if (s2_q.frac_nz) begin
          inx = 1'b1;
          res = s2_q.trunc + s2_q.unit;
        end
      end
      default: res = s2_q.x;
    endcase
    if (s2_q.single) res[63:32] = 32'd0;
    s3_d = {inx, res};
  end

  frti_stage u_s3 (
    .clk(clk), .rst(rst), .in_valid(v2), .in_ready(r2),
    .out_valid(out_valid), .out_ready(out_ready), .load(ld3)
  );

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_q <= s3_d;
    end
  end

  assign result_bits = s3_q[63:0];
  assign inexact     = s3_q[64];

endmodule

// ===== rtl/frti_stage.sv =====
// frti_stage: valid and ready control of one pipeline register slot
// no dependencies; the slot's data register lives with the caller
`timescale 1ns / 1ps

module frti_stage (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic load
);

  // slot is free when empty or draining this cycle
  assign in_ready = !out_valid || out_ready;

  // data register captures on every accepted transaction
  assign load = in_ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== rtl/frti_checker.sv =====
// frti_checker: port-level assertions for fp_round_to_integral_core
// depends on fp_round_to_integral_core ports only
`timescale 1ns / 1ps

module frti_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_bits,
  input logic        inexact
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_bits) && $stable(inexact))
    else $error("stalled output changed");

  // a free output slot never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // input is only blocked by a stalled result
  a_block: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  // no output straight after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind fp_round_to_integral_core frti_checker u_frti_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .result_bits(result_bits), .inexact(inexact)
);
